// File: hdl/dccc_pkg.sv
// Shared constants of the Dragon cache controller: opcodes, line states,
// bus request codes and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package dccc_pkg;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;
    localparam int ID_W   = 8;
    localparam int OP_W   = 2;
    localparam int REQ_W  = 2;
    localparam int ST_W   = 3;
    localparam int DATA_W = 32;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_CPU_RD = 2'd0;
    localparam logic [OP_W-1:0] OP_CPU_WR = 2'd1;
    localparam logic [OP_W-1:0] OP_BUS_RD = 2'd2;
    localparam logic [OP_W-1:0] OP_BUS_UP = 2'd3;

    // Dragon line states.
    localparam logic [ST_W-1:0] ST_I  = 3'd0;
    localparam logic [ST_W-1:0] ST_E  = 3'd1;
    localparam logic [ST_W-1:0] ST_SC = 3'd2;
    localparam logic [ST_W-1:0] ST_SM = 3'd3;
    localparam logic [ST_W-1:0] ST_M  = 3'd4;

    // Bus request codes.
    localparam logic [REQ_W-1:0] REQ_NONE    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ_UP = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UPDATE  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_NODE_ID = 1'b0;

    // Depth of the queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

endpackage

// File: hdl/dccc_front.sv
// Front end of the Dragon cache controller: accepts requests, masks the address
// and reduces it to a block number, and holds them in a short queue.
// Depends on dccc_pkg.
`timescale 1ns / 1ps

module dccc_front import dccc_pkg::*; #(
    parameter int BLOCK_BYTES  = 64,
    parameter int ADDRESS_BITS = 32,
    parameter int BLK_W        = ADDR_W - $clog2(BLOCK_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [ADDR_W-1:0] i_address,
    input  logic              i_shared,
    output logic              o_q_full,
    output logic              o_q_valid,
    output logic [OP_W-1:0]   o_q_op,
    output logic [BLK_W-1:0]  o_q_blk,
    output logic              o_q_shared,
    input  logic              i_q_pop
);

    localparam int OFF_W = $clog2(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                                              : ~({ADDR_W{1'b1}} << ADDRESS_BITS);

    logic [OP_W-1:0]   r_q_op     [QDEPTH];
    logic [BLK_W-1:0]  r_q_blk    [QDEPTH];
    logic              r_q_shared [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic [ADDR_W-1:0] masked_addr;
    logic              do_push;
    logic              do_pop;

    assign masked_addr = i_address & ADDR_MASK;
    assign o_q_full    = (r_count == QCNT_W'(QDEPTH));
    assign o_q_valid   = (r_count != '0);
    assign do_push     = i_push && !o_q_full;
    assign do_pop      = i_q_pop && o_q_valid;

    assign o_q_op     = r_q_op[r_rd_ptr];
    assign o_q_blk    = r_q_blk[r_rd_ptr];
    assign o_q_shared = r_q_shared[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q_op[r_wr_ptr]     <= i_opcode;
            r_q_blk[r_wr_ptr]    <= masked_addr[ADDR_W-1:OFF_W];
            r_q_shared[r_wr_ptr] <= i_shared;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/dccc_back.sv
// Back end of the Dragon cache controller: line state and tag arrays, protocol
// transitions, saturating counters and the result register.
// Depends on dccc_pkg.
`timescale 1ns / 1ps

module dccc_back import dccc_pkg::*; #(
    parameter int INDEX_BITS  = 10,
    parameter int BLOCK_BYTES = 64,
    parameter int BLK_W       = ADDR_W - $clog2(BLOCK_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  logic [OP_W-1:0]   i_q_op,
    input  logic [BLK_W-1:0]  i_q_blk,
    input  logic              i_q_shared,
    output logic              o_q_pop,
    input  logic [ID_W-1:0]   i_node_id,
    output logic              o_clearing,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_hit,
    output logic [REQ_W-1:0]  o_bus_request,
    output logic [ID_W-1:0]   o_bus_source_id,
    output logic              o_writeback,
    output logic [ADDR_W-1:0] o_writeback_address,
    output logic              o_snoop_has_block,
    output logic              o_update_accepted,
    output logic [CNT_W-1:0]  o_access_count,
    output logic [CNT_W-1:0]  o_hit_count,
    output logic [CNT_W-1:0]  o_miss_count
);

    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int TAG_W  = BLK_W - INDEX_BITS;
    localparam int NLINES = 1 << INDEX_BITS;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [ST_W-1:0]  r_mem_state [0:NLINES-1];
    logic [TAG_W-1:0] r_mem_tag   [0:NLINES-1];

    logic [1:0]            r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_idx;
    logic [OP_W-1:0]       r_op;
    logic                  r_shared;
    logic [INDEX_BITS-1:0] r_idx;
    logic [TAG_W-1:0]      r_tag;
    logic [ST_W-1:0]       r_rd_state;
    logic [TAG_W-1:0]      r_rd_tag;
    logic [CNT_W-1:0]      r_accesses, r_hits, r_misses;
    logic [CNT_W-1:0]      n_accesses, n_hits, n_misses;

    logic                  r_o_valid;
    logic                  r_o_hit;
    logic [REQ_W-1:0]      r_o_req;
    logic [ID_W-1:0]       r_o_id;
    logic                  r_o_wb;
    logic [ADDR_W-1:0]     r_o_wba;
    logic                  r_o_has;
    logic                  r_o_acc;

    logic                  look_hit;
    logic                  look_cpu;
    logic [ST_W-1:0]       look_st;
    logic [REQ_W-1:0]      look_req;
    logic                  look_wb;
    logic [ADDR_W-1:0]     look_wba;
    logic                  look_has;
    logic                  look_acc;
    logic                  look_done;

    logic                  st_we;
    logic [INDEX_BITS-1:0] st_wa;
    logic [ST_W-1:0]       st_wd;
    logic                  tag_we;

    assign o_clearing = (r_state == S_CLEAR);
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    // The result register is free when empty or being drained this cycle.
    assign look_done  = (r_state == S_LOOK) && (!r_o_valid || i_pop);

    // Protocol decision on the looked-up line.
    always_comb begin
        look_hit = (r_rd_state != ST_I) && (r_rd_tag == r_tag);
        look_cpu = (r_op == OP_CPU_RD) || (r_op == OP_CPU_WR);
        look_st  = r_rd_state;
        look_req = REQ_NONE;
        look_wb  = 1'b0;
        look_wba = '0;
        look_has = 1'b0;
        look_acc = 1'b1;
        n_accesses = r_accesses;
        n_hits     = r_hits;
        n_misses   = r_misses;
        case (r_op)
            OP_CPU_RD, OP_CPU_WR: begin
                n_accesses = (r_accesses == '1) ? r_accesses : r_accesses + 1'b1;
                if (look_hit) begin
                    n_hits = (r_hits == '1) ? r_hits : r_hits + 1'b1;
                end else begin
                    n_misses = (r_misses == '1) ? r_misses : r_misses + 1'b1;
                end
                if (!look_hit) begin
                    if ((r_rd_state == ST_SM) || (r_rd_state == ST_M)) begin
                        look_wb  = 1'b1;
                        look_wba = {r_rd_tag, r_idx, {OFF_W{1'b0}}};
                    end
                    if (r_op == OP_CPU_RD) begin
                        look_req = REQ_READ;
                        look_st  = r_shared ? ST_SC : ST_E;
                    end else begin
                        look_req = r_shared ? REQ_READ_UP : REQ_READ;
                        look_st  = r_shared ? ST_SM : ST_M;
                    end
                end else if (r_op == OP_CPU_WR) begin
                    if ((r_rd_state == ST_SC) || (r_rd_state == ST_SM)) begin
                        look_req = REQ_UPDATE;
                        look_st  = r_shared ? ST_SM : ST_M;
                    end else begin
                        look_st  = ST_M;
                    end
                end
            end
            OP_BUS_RD: begin
                if (look_hit) begin
                    look_has = 1'b1;
                    if (r_rd_state == ST_E) begin
                        look_st = ST_SC;
                    end else if (r_rd_state == ST_M) begin
                        look_st = ST_SM;
                    end
                end
            end
            OP_BUS_UP: begin
                if (look_hit) begin
                    if ((r_rd_state == ST_E) || (r_rd_state == ST_M)) begin
                        look_acc = 1'b0;
                    end else if (r_rd_state == ST_SM) begin
                        look_st = ST_SC;
                    end
                end
            end
            default: begin
                look_st = r_rd_state;
            end
        endcase
    end

    always_comb begin
        st_we  = 1'b0;
        st_wa  = r_idx;
        st_wd  = look_st;
        tag_we = look_done && look_cpu && !look_hit;
        if (r_state == S_CLEAR) begin
            st_we = 1'b1;
            st_wa = r_clr_idx;
            st_wd = ST_I;
        end else if (look_done) begin
            st_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_mem_state[st_wa] <= st_wd;
        end
        if (o_q_pop) begin
            r_rd_state <= r_mem_state[i_q_blk[INDEX_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_mem_tag[r_idx] <= r_tag;
        end
        if (o_q_pop) begin
            r_rd_tag <= r_mem_tag[i_q_blk[INDEX_BITS-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (look_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Request fields and result payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op     <= i_q_op;
            r_shared <= i_q_shared;
            r_idx    <= i_q_blk[INDEX_BITS-1:0];
            r_tag    <= i_q_blk[BLK_W-1:INDEX_BITS];
        end
        if (look_done) begin
            r_o_hit <= look_hit;
            r_o_req <= look_req;
            r_o_id  <= (look_req != REQ_NONE) ? i_node_id : '0;
            r_o_wb  <= look_wb;
            r_o_wba <= look_wba;
            r_o_has <= look_has;
            r_o_acc <= look_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_idx  <= '0;
            r_accesses <= '0;
            r_hits     <= '0;
            r_misses   <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (look_done) begin
                r_accesses <= n_accesses;
                r_hits     <= n_hits;
                r_misses   <= n_misses;
                r_o_valid  <= 1'b1;
            end else if (i_pop) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_empty             = !r_o_valid;
    assign o_hit               = r_o_hit;
    assign o_bus_request       = r_o_req;
    assign o_bus_source_id     = r_o_id;
    assign o_writeback         = r_o_wb;
    assign o_writeback_address = r_o_wba;
    assign o_snoop_has_block   = r_o_has;
    assign o_update_accepted   = r_o_acc;
    assign o_access_count      = r_accesses;
    assign o_hit_count         = r_hits;
    assign o_miss_count        = r_misses;

endmodule

// File: hdl/dragon_coherent_cache_controller_unit.sv
// Top level of the Dragon cache controller: configuration register port,
// front end and back end. Depends on dccc_pkg, dccc_front and dccc_back.
// Usage:
// Requests enter through a queue interface: a request is taken at a clock edge
// with push high and full low. Each request is a cpu read or write or a snooped
// bus read or update with its byte address and the bus shared line.
// Results leave through a queue interface: while empty is low the oldest result
// is on the result ports, and it is taken at an edge with pop high.
// Every request yields exactly one result.
// In the back end a request first reads the state and tag arrays and then updates
// them, and the back end takes no new request until the last one is through.
// Results are registered: a request passes the queue, the array read and the lookup.
// A two-entry queue decouples the input from the back end, and a result
// register decouples the back end from the receiver; when the receiver stalls
// the back end holds its request and the queue keeps taking requests until full.
// After reset the state array is swept to invalid, one line per cycle, over all
// 2**INDEX_BITS lines; full stays high during the sweep. The identifier register
// is written over the APB port at address 0 by the user, only while no request is
// in flight (unchecked); a queued request picks up the value current at its lookup.
`timescale 1ns / 1ps

module dragon_coherent_cache_controller_unit import dccc_pkg::*; #(
    parameter int INDEX_BITS   = 10,
    parameter int BLOCK_BYTES  = 64,
    parameter int ADDRESS_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [ADDR_W-1:0] i_address,
    input  logic              i_shared,
    output logic              empty,
    input  logic              pop,
    output logic              o_hit,
    output logic [REQ_W-1:0]  o_bus_request,
    output logic [ID_W-1:0]   o_bus_source_id,
    output logic              o_writeback,
    output logic [ADDR_W-1:0] o_writeback_address,
    output logic              o_snoop_has_block,
    output logic              o_update_accepted,
    output logic [CNT_W-1:0]  o_access_count,
    output logic [CNT_W-1:0]  o_hit_count,
    output logic [CNT_W-1:0]  o_miss_count
);

    localparam int BLK_W = ADDR_W - $clog2(BLOCK_BYTES);

    logic [ID_W-1:0]  r_node_id;
    logic             reg_index;
    logic             q_full;
    logic             q_valid;
    logic [OP_W-1:0]  q_op;
    logic [BLK_W-1:0] q_blk;
    logic             q_shared;
    logic             q_pop;
    logic             clearing;

    assign reg_index = paddr[2];
    assign pready    = 1'b1;
    assign prdata    = (reg_index == REG_NODE_ID)
                       ? {{(DATA_W-ID_W){1'b0}}, r_node_id} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= '0;
        end else if (psel && penable && pwrite && (reg_index == REG_NODE_ID)) begin
            r_node_id <= pwdata[ID_W-1:0];
        end
    end

    assign full = q_full || clearing;

    dccc_front #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS),
        .BLK_W        (BLK_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push && !clearing),
        .i_opcode   (i_opcode),
        .i_address  (i_address),
        .i_shared   (i_shared),
        .o_q_full   (q_full),
        .o_q_valid  (q_valid),
        .o_q_op     (q_op),
        .o_q_blk    (q_blk),
        .o_q_shared (q_shared),
        .i_q_pop    (q_pop)
    );

    dccc_back #(
        .INDEX_BITS  (INDEX_BITS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .BLK_W       (BLK_W)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_op              (q_op),
        .i_q_blk             (q_blk),
        .i_q_shared          (q_shared),
        .o_q_pop             (q_pop),
        .i_node_id           (r_node_id),
        .o_clearing          (clearing),
        .i_pop               (pop),
        .o_empty             (empty),
        .o_hit               (o_hit),
        .o_bus_request       (o_bus_request),
        .o_bus_source_id     (o_bus_source_id),
        .o_writeback         (o_writeback),
        .o_writeback_address (o_writeback_address),
        .o_snoop_has_block   (o_snoop_has_block),
        .o_update_accepted   (o_update_accepted),
        .o_access_count      (o_access_count),
        .o_hit_count         (o_hit_count),
        .o_miss_count        (o_miss_count)
    );

endmodule

// File: hdl/dccc_checker.sv
// Port-level checks for the Dragon cache controller and the bind that attaches
// them to the top level. Depends on dccc_pkg and the top level.
`timescale 1ns / 1ps

module dccc_checker import dccc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic              o_hit,
    input logic [REQ_W-1:0]  o_bus_request,
    input logic [ID_W-1:0]   o_bus_source_id,
    input logic              o_writeback,
    input logic [ADDR_W-1:0] o_writeback_address,
    input logic [CNT_W-1:0]  o_access_count,
    input logic [CNT_W-1:0]  o_hit_count,
    input logic [CNT_W-1:0]  o_miss_count
);

    // Reset starts the array sweep with no result pending.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> full && empty)
        else $error("controller not full and empty after reset");

    // A result that is not taken stays as it is.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_hit) && $stable(o_bus_request)
            && $stable(o_writeback_address) && $stable(o_access_count))
        else $error("stalled result changed");

    // Until saturation every processor access is either a hit or a miss.
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_access_count != {CNT_W{1'b1}})
            |-> ({1'b0, o_hit_count} + {1'b0, o_miss_count}) == {1'b0, o_access_count})
        else $error("hit and miss counts do not add up to access count");

    // A writeback only comes from a processor miss, which always goes on the bus.
    a_writeback_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_writeback |-> !o_hit && (o_bus_request != REQ_NONE)
            && (o_bus_request != REQ_UPDATE))
        else $error("writeback without a processor miss");

    // No request on the bus carries no source identifier.
    a_idle_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_bus_request == REQ_NONE) |-> (o_bus_source_id == '0)
            && (o_writeback || (o_writeback_address == '0)))
        else $error("source id or writeback address set without a request");

endmodule

bind dragon_coherent_cache_controller_unit dccc_checker u_dccc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .full                (full),
    .empty               (empty),
    .pop                 (pop),
    .o_hit               (o_hit),
    .o_bus_request       (o_bus_request),
    .o_bus_source_id     (o_bus_source_id),
    .o_writeback         (o_writeback),
    .o_writeback_address (o_writeback_address),
    .o_access_count      (o_access_count),
    .o_hit_count         (o_hit_count),
    .o_miss_count        (o_miss_count)
);

// File: bench/dccc_lookup_checker.sv
// Checker for the Dragon cache controller: predicts every lookup result from the
// accepted requests and compares it with the result taken from the block.
// Depends on dccc_pkg for field widths, opcodes, line states and request codes.
`timescale 1ns / 1ps

module dccc_lookup_checker import dccc_pkg::*; #(
    parameter int INDEX_BITS  = 10,
    parameter int OFFSET_BITS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    input  logic              push,
    input  logic              full,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [ADDR_W-1:0] i_address,
    input  logic              i_shared,
    input  logic              empty,
    input  logic              pop,
    input  logic              o_hit,
    input  logic [REQ_W-1:0]  o_bus_request,
    input  logic [ID_W-1:0]   o_bus_source_id,
    input  logic              o_writeback,
    input  logic [ADDR_W-1:0] o_writeback_address,
    input  logic              o_snoop_has_block,
    input  logic              o_update_accepted,
    input  logic [CNT_W-1:0]  o_access_count,
    input  logic [CNT_W-1:0]  o_hit_count,
    input  logic [CNT_W-1:0]  o_miss_count,
    output int                o_mismatches,
    output int                o_outstanding
);

    localparam int TAG_BITS = ADDR_W - INDEX_BITS - OFFSET_BITS;
    localparam int LINES    = 1 << INDEX_BITS;
    localparam logic [2:0] NODE_ID_ADDR = {REG_NODE_ID, 2'b00};

    typedef struct packed {
        logic              hit;
        logic [REQ_W-1:0]  bus_request;
        logic [ID_W-1:0]   source_id;
        logic              writeback;
        logic [ADDR_W-1:0] writeback_addr;
        logic              snoop_has;
        logic              update_ok;
        logic [CNT_W-1:0]  accesses;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
    } lookup_result_t;

    logic [ST_W-1:0]     line_st  [LINES];
    logic [TAG_BITS-1:0] line_tag [LINES];
    logic [CNT_W-1:0]    access_cnt;
    logic [CNT_W-1:0]    hit_cnt;
    logic [CNT_W-1:0]    miss_cnt;
    logic [ID_W-1:0]     node_id;

    lookup_result_t expected_results [$];
    lookup_result_t want;
    lookup_result_t got;
    int             mismatch_count = 0;
    int             pending_count  = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = pending_count;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Looks up the line, applies the Dragon transition and returns what the
    // block should report for this request.
    function automatic lookup_result_t predict_lookup(input logic [OP_W-1:0] op,
                                                      input logic [ADDR_W-1:0] addr,
                                                      input logic sh);
        lookup_result_t        r;
        logic [INDEX_BITS-1:0] idx;
        logic [TAG_BITS-1:0]   tag;
        logic [ST_W-1:0]       st;
        logic                  hit;
        idx = addr[OFFSET_BITS +: INDEX_BITS];
        tag = addr[ADDR_W-1 -: TAG_BITS];
        st  = line_st[idx];
        hit = (st != ST_I) && (line_tag[idx] == tag);
        r = '0;
        r.update_ok = 1'b1;
        if (op == OP_CPU_RD || op == OP_CPU_WR) begin
            access_cnt = sat_inc(access_cnt);
            if (hit) begin
                hit_cnt = sat_inc(hit_cnt);
            end else begin
                miss_cnt = sat_inc(miss_cnt);
            end
            if (!hit) begin
                // Only a dirty victim goes back to memory.
                if (st == ST_SM || st == ST_M) begin
                    r.writeback      = 1'b1;
                    r.writeback_addr = {line_tag[idx], idx, {OFFSET_BITS{1'b0}}};
                end
                line_tag[idx] = tag;
                if (op == OP_CPU_RD) begin
                    r.bus_request = REQ_READ;
                    line_st[idx]  = sh ? ST_SC : ST_E;
                end else begin
                    r.bus_request = sh ? REQ_READ_UP : REQ_READ;
                    line_st[idx]  = sh ? ST_SM : ST_M;
                end
            end else if (op == OP_CPU_WR) begin
                if (st == ST_SC || st == ST_SM) begin
                    r.bus_request = REQ_UPDATE;
                    line_st[idx]  = sh ? ST_SM : ST_M;
                end else begin
                    line_st[idx] = ST_M;
                end
            end
        end else if (op == OP_BUS_RD) begin
            if (hit) begin
                r.snoop_has = 1'b1;
                if (st == ST_E) begin
                    line_st[idx] = ST_SC;
                end else if (st == ST_M) begin
                    line_st[idx] = ST_SM;
                end
            end
        end else if (hit) begin
            // An update aimed at a line that no one else may hold is refused.
            if (st == ST_E || st == ST_M) begin
                r.update_ok = 1'b0;
            end else if (st == ST_SM) begin
                line_st[idx] = ST_SC;
            end
        end
        r.hit       = hit;
        r.source_id = (r.bus_request != REQ_NONE) ? node_id : '0;
        r.accesses  = access_cnt;
        r.hits      = hit_cnt;
        r.misses    = miss_cnt;
        return r;
    endfunction

    task automatic report_failure(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v) begin
            report_failure($sformatf("%s expected %0h, got %0h", name, want_v, got_v));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                line_st[i]  = ST_I;
                line_tag[i] = '0;
            end
            access_cnt = '0;
            hit_cnt    = '0;
            miss_cnt   = '0;
            node_id    = '0;
            expected_results.delete();
        end else begin
            if (pop && !empty) begin
                got.hit            = o_hit;
                got.bus_request    = o_bus_request;
                got.source_id      = o_bus_source_id;
                got.writeback      = o_writeback;
                got.writeback_addr = o_writeback_address;
                got.snoop_has      = o_snoop_has_block;
                got.update_ok      = o_update_accepted;
                got.accesses       = o_access_count;
                got.hits           = o_hit_count;
                got.misses         = o_miss_count;
                if (expected_results.size() == 0) begin
                    report_failure("result taken with no request pending");
                end else begin
                    want = expected_results.pop_front();
                    compare_field("hit", 32'(want.hit), 32'(got.hit));
                    compare_field("bus_request", 32'(want.bus_request),
                                  32'(got.bus_request));
                    compare_field("bus_source_id", 32'(want.source_id),
                                  32'(got.source_id));
                    compare_field("writeback", 32'(want.writeback), 32'(got.writeback));
                    compare_field("writeback_address", want.writeback_addr,
                                  got.writeback_addr);
                    compare_field("snoop_has_block", 32'(want.snoop_has),
                                  32'(got.snoop_has));
                    compare_field("update_accepted", 32'(want.update_ok),
                                  32'(got.update_ok));
                    compare_field("access_count", want.accesses, got.accesses);
                    compare_field("hit_count", want.hits, got.hits);
                    compare_field("miss_count", want.misses, got.misses);
                end
            end
            if (push && !full) begin
                expected_results.push_back(predict_lookup(i_opcode, i_address, i_shared));
            end
            if (psel && penable && pwrite && pready && paddr == NODE_ID_ADDR) begin
                node_id = pwdata[ID_W-1:0];
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// File: bench/dragon_coherent_cache_controller_unit_test.sv
// Top of the Dragon cache controller test: clock, reset, register writes, a
// directed walk through the protocol states and random request traffic.
// Depends on dccc_pkg, dragon_coherent_cache_controller_unit and dccc_lookup_checker.
`timescale 1ns / 1ps

module dragon_coherent_cache_controller_unit_test import dccc_pkg::*;;

    localparam int INDEX_W  = 10;
    localparam int OFFSET_W = 6;
    localparam int TAG_W    = ADDR_W - INDEX_W - OFFSET_W;
    localparam logic [2:0] ADDR_NODE_ID   = {REG_NODE_ID, 2'b00};
    localparam logic [2:0] PADDR_UNMAPPED = 3'd4;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [2:0]        paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              push      = 1'b0;
    logic              full;
    logic [OP_W-1:0]   i_opcode  = OP_CPU_RD;
    logic [ADDR_W-1:0] i_address = '0;
    logic              i_shared  = 1'b0;
    logic              empty;
    logic              pop       = 1'b0;
    logic              o_hit;
    logic [REQ_W-1:0]  o_bus_request;
    logic [ID_W-1:0]   o_bus_source_id;
    logic              o_writeback;
    logic [ADDR_W-1:0] o_writeback_address;
    logic              o_snoop_has_block;
    logic              o_update_accepted;
    logic [CNT_W-1:0]  o_access_count;
    logic [CNT_W-1:0]  o_hit_count;
    logic [CNT_W-1:0]  o_miss_count;
    int                mismatches;
    int                outstanding;

    logic              push_taken = 1'b0;
    logic              apb_taken  = 1'b0;
    int                burst_left = 0;
    int                rx_mode    = 0;
    int                rx_hold    = 0;
    int                rx_tick    = 0;
    logic [TAG_W-1:0]   tag_pool   [4];
    logic [INDEX_W-1:0] index_pool [6];

    dragon_coherent_cache_controller_unit #(
        .INDEX_BITS  (INDEX_W),
        .BLOCK_BYTES (1 << OFFSET_W),
        .ADDRESS_BITS(ADDR_W)
    ) dut (.*);

    dccc_lookup_checker #(
        .INDEX_BITS (INDEX_W),
        .OFFSET_BITS(OFFSET_W)
    ) checker_inst (
        .*,
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        push_taken <= push && !full;
        apb_taken  <= psel && penable && pwrite && pready;
    end

    // The receiver switches between free-running, random, sparse and periodic
    // popping, holding each mode for a random stretch.
    always @(negedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_hold = $urandom_range(16, 96);
        end
        rx_hold--;
        rx_tick++;
        case (rx_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 7) == 0);
            default: pop <= (rx_tick % 5) != 4;
        endcase
    end

    task automatic write_register(input logic [2:0] addr, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!apb_taken) @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                input logic sh);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        push      <= 1'b1;
        i_opcode  <= op;
        i_address <= addr;
        i_shared  <= sh;
        @(negedge i_clk);
        while (!push_taken) @(negedge i_clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] line_address(input logic [TAG_W-1:0] tag,
                                                       input logic [INDEX_W-1:0] idx,
                                                       input logic [OFFSET_W-1:0] off);
        return {tag, idx, off};
    endfunction

    // Few tags over few lines so that hits, evictions and snoop matches are common.
    task automatic refresh_pools();
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = TAG_W'($urandom);
        tag_pool[3] = TAG_W'($urandom);
        index_pool[0] = '0;
        index_pool[1] = '1;
        for (int i = 2; i < 6; i++) begin
            index_pool[i] = INDEX_W'($urandom);
        end
    endtask

    task automatic random_phase(input int count);
        int                sent;
        int                run;
        int                pick;
        logic [ADDR_W-1:0] addr;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 7) == 0) begin
                addr = $urandom;
            end else begin
                addr = line_address(tag_pool[$urandom_range(0, 3)],
                                    index_pool[$urandom_range(0, 5)], '0);
            end
            // A run of requests to one block walks it through several states.
            run = $urandom_range(1, 6);
            repeat (run) begin
                pick = $urandom_range(0, 99);
                addr[OFFSET_W-1:0] = OFFSET_W'($urandom);
                send_request(pick < 35 ? OP_CPU_RD : pick < 65 ? OP_CPU_WR :
                             pick < 85 ? OP_BUS_RD : OP_BUS_UP,
                             addr, 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial begin
        logic [DATA_W-1:0] id_values [4];
        logic [TAG_W-1:0]  t1;
        logic [TAG_W-1:0]  t2;
        logic [TAG_W-1:0]  t3;
        logic [INDEX_W-1:0] ix;
        t1 = 16'h1234;
        t2 = 16'hABCD;
        t3 = 16'h0F0F;
        ix = 10'd5;
        id_values[0] = '0;
        id_values[1] = 32'h0000_00FF;
        id_values[2] = $urandom;
        id_values[3] = $urandom;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_register(ADDR_NODE_ID, 32'hA5A5_5AA5);
        // A write to an unmapped address must leave the identifier alone.
        write_register(PADDR_UNMAPPED, 32'hFFFF_FFFF);

        send_request(OP_CPU_RD, line_address(t1, ix, 6'd0), 1'b0);
        send_request(OP_BUS_UP, line_address(t1, ix, 6'd1), 1'b0);
        send_request(OP_BUS_RD, line_address(t1, ix, 6'd2), 1'b1);
        send_request(OP_CPU_WR, line_address(t1, ix, 6'd3), 1'b1);
        send_request(OP_BUS_RD, line_address(t1, ix, 6'd4), 1'b0);
        send_request(OP_BUS_UP, line_address(t1, ix, 6'd5), 1'b1);
        send_request(OP_CPU_WR, line_address(t1, ix, 6'd6), 1'b0);
        send_request(OP_BUS_UP, line_address(t1, ix, 6'd7), 1'b0);
        send_request(OP_BUS_RD, line_address(t1, ix, 6'd8), 1'b0);
        send_request(OP_CPU_RD, line_address(t2, ix, 6'd9), 1'b1);
        // A snoop read under another tag and a snoop update of the held clean shared line must change nothing.
        send_request(OP_BUS_RD, line_address(t1, ix, 6'd10), 1'b0);
        send_request(OP_BUS_UP, line_address(t2, ix, 6'd11), 1'b0);
        send_request(OP_CPU_WR, line_address(t3, ix, 6'd12), 1'b1);
        send_request(OP_CPU_WR, line_address(t1, ix, 6'd13), 1'b0);
        send_request(OP_CPU_WR, line_address(t1, ix, 6'd14), 1'b1);
        send_request(OP_CPU_RD, line_address(t2, ix, 6'd15), 1'b0);
        send_request(OP_CPU_WR, line_address(t2, ix, 6'd16), 1'b1);
        send_request(OP_CPU_RD, 32'h0000_0000, 1'b1);
        send_request(OP_CPU_WR, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_CPU_RD, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_BUS_RD, line_address(t1, 10'd7, 6'd0), 1'b1);
        send_request(OP_BUS_UP, line_address(t1, 10'd8, 6'd63), 1'b1);
        send_request(OP_CPU_WR, 32'h0000_003F, 1'b0);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            write_register(ADDR_NODE_ID, id_values[p]);
            refresh_pools();
            random_phase(450);
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
